[rtl/itwg_pkg.sv]
`timescale 1ns / 1ps

package itwg_pkg;

    // Kernel kind carried with each job from the front to the back
    typedef enum logic [1:0] {
        KIND_NEAREST = 2'd0,
        KIND_LINEAR  = 2'd1,
        KIND_CUBIC   = 2'd2
    } t_kind;

    // interp_mode register codes
    localparam logic [1:0] MODE_NEAREST = 2'd0;
    localparam logic [1:0] MODE_LINEAR  = 2'd1;
    localparam logic [1:0] MODE_CUBIC   = 2'd2;

    // Register index (paddr bit 2)
    localparam logic [0:0] REG_INTERP_MODE = 1'b0;

    // Axis weights held over more fraction bits than this are rounded down to it
    localparam int AXIS_MAX_FRAC = 30;

    // Queue depths
    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // Job handshake between front and back
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_job_ctl;

endpackage

[rtl/itwg_queue.sv]
`timescale 1ns / 1ps

module itwg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic                           i_rd,
    output logic [WIDTH-1:0]               o_rdata,
    output logic                           o_empty,
    output logic                           o_full,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CW'(i_wr) - CW'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;

    // Writers must respect occupancy, readers must not drain an empty queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_count != CW'(DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> (r_count != '0))
        else $error("queue read while empty");

endmodule

[rtl/itwg_front.sv]
`timescale 1ns / 1ps

module itwg_front #(
    parameter int FRAC_BITS = 8,
    parameter int INT_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic signed [INT_BITS+FRAC_BITS-1:0]   i_x_coord,
    input  logic signed [INT_BITS+FRAC_BITS-1:0]   i_y_coord,
    input  logic [1:0]                             i_mode,
    input  logic                                   i_job_full,
    output itwg_pkg::t_job_ctl                     o_job,
    output logic signed [INT_BITS:0]               o_x0,
    output logic signed [INT_BITS:0]               o_y0,
    output logic [3:0][((3*FRAC_BITS+1 > itwg_pkg::AXIS_MAX_FRAC) ?
                       itwg_pkg::AXIS_MAX_FRAC : 3*FRAC_BITS+1)+1:0] o_wx,
    output logic [3:0][((3*FRAC_BITS+1 > itwg_pkg::AXIS_MAX_FRAC) ?
                       itwg_pkg::AXIS_MAX_FRAC : 3*FRAC_BITS+1)+1:0] o_wy
);

    localparam int IN_W   = INT_BITS + FRAC_BITS;
    localparam int TAP_W  = INT_BITS + 1;
    localparam int CUB_D  = 3 * FRAC_BITS + 1;
    localparam int RED_SH = (CUB_D > itwg_pkg::AXIS_MAX_FRAC) ?
                            CUB_D - itwg_pkg::AXIS_MAX_FRAC : 0;
    localparam int AX_D   = CUB_D - RED_SH;
    localparam int AX_W   = AX_D + 2;
    localparam int RAW_W  = 3 * FRAC_BITS + 5;
    localparam logic [RAW_W-1:0] RED_HALF =
        RAW_W'(RED_SH > 0) << ((RED_SH > 0) ? RED_SH - 1 : 0);
    localparam logic [IN_W:0] RND_HALF = (IN_W + 1)'(1) << (FRAC_BITS - 1);

    // Integer part, floor toward minus infinity
    function automatic logic signed [TAP_W-1:0] floor_int(
        input logic signed [IN_W-1:0] c
    );
        logic signed [IN_W-1:0] sh;
        sh = c >>> FRAC_BITS;
        return TAP_W'(sh);
    endfunction

    // Nearest integer, a half rounds away from zero
    function automatic logic signed [TAP_W-1:0] round_int(
        input logic signed [IN_W-1:0] c
    );
        logic signed [IN_W:0] ce;
        logic [IN_W:0]        mag;
        logic [IN_W:0]        r;
        ce  = (IN_W + 1)'(c);
        mag = ce[IN_W] ? -ce : ce;
        r   = (mag + RND_HALF) >> FRAC_BITS;
        return ce[IN_W] ? -TAP_W'(r) : TAP_W'(r);
    endfunction

    // Unreduced axis weights: cubic over 2^(3F+1), linear over 2^F
    function automatic logic [3:0][RAW_W-1:0] axis_raw(
        input itwg_pkg::t_kind       k,
        input logic [FRAC_BITS-1:0]   t,
        input logic [2*FRAC_BITS-1:0] t2,
        input logic [3*FRAC_BITS-1:0] t3
    );
        logic signed [RAW_W-1:0] a1, a2, a3, one, s3;
        logic [3:0][RAW_W-1:0]   w;
        a1  = RAW_W'(t);
        a2  = RAW_W'(t2);
        a3  = RAW_W'(t3);
        one = RAW_W'(1) << FRAC_BITS;
        s3  = RAW_W'(1) << (3 * FRAC_BITS + 1);
        w   = '0;
        case (k)
            itwg_pkg::KIND_LINEAR: begin
                w[0] = one - a1;
                w[1] = a1;
            end
            itwg_pkg::KIND_NEAREST: begin
                w = '0;
            end
            default: begin
                w[0] = -a3 + (a2 << (FRAC_BITS + 1)) - (a1 << (2 * FRAC_BITS));
                w[1] = (a3 << 1) + a3 - (a2 << (FRAC_BITS + 2)) - (a2 << FRAC_BITS) + s3;
                w[2] = -(a3 << 1) - a3 + (a2 << (FRAC_BITS + 2)) + (a1 << (2 * FRAC_BITS));
                w[3] = a3 - (a2 << FRAC_BITS);
            end
        endcase
        return w;
    endfunction

    // Cubic weights rounded to at most AXIS_MAX_FRAC fraction bits
    function automatic logic [AX_W-1:0] axis_fit(
        input itwg_pkg::t_kind  k,
        input logic [RAW_W-1:0] w
    );
        logic signed [RAW_W-1:0] v;
        logic [RAW_W-1:0]        mag;
        logic [RAW_W-1:0]        r;
        v   = w;
        mag = v[RAW_W-1] ? -v : v;
        r   = (mag + RED_HALF) >> RED_SH;
        if (k == itwg_pkg::KIND_CUBIC) begin
            return AX_W'(v[RAW_W-1] ? -r : r);
        end
        return AX_W'(w);
    endfunction

    logic w_en;

    // Stage 0: captured transaction
    logic                    r0_valid;
    itwg_pkg::t_kind         r0_kind, n0_kind;
    logic signed [IN_W-1:0]  r0_x, r0_y;

    // Stage 1: split, squares
    logic                        r1_valid;
    itwg_pkg::t_kind             r1_kind;
    logic signed [TAP_W-1:0]     r1_x0, r1_y0, n1_x0, n1_y0;
    logic [FRAC_BITS-1:0]        r1_tx, r1_ty;
    logic [2*FRAC_BITS-1:0]      r1_tx2, r1_ty2;

    // Stage 2: cubes
    logic                        r2_valid;
    itwg_pkg::t_kind             r2_kind;
    logic signed [TAP_W-1:0]     r2_x0, r2_y0;
    logic [FRAC_BITS-1:0]        r2_tx, r2_ty;
    logic [2*FRAC_BITS-1:0]      r2_tx2, r2_ty2;
    logic [3*FRAC_BITS-1:0]      r2_tx3, r2_ty3;

    // Stage 3: raw axis weights
    logic                        r3_valid;
    itwg_pkg::t_kind             r3_kind;
    logic signed [TAP_W-1:0]     r3_x0, r3_y0;
    logic [3:0][RAW_W-1:0]       r3_wx, r3_wy;

    // The whole pipe holds while the job queue refuses the last stage
    assign w_en   = !(r3_valid && i_job_full);
    assign o_full = !w_en;

    // Mode to kernel kind; the unused code runs as cubic
    always_comb begin
        case (i_mode)
            itwg_pkg::MODE_NEAREST: n0_kind = itwg_pkg::KIND_NEAREST;
            itwg_pkg::MODE_LINEAR:  n0_kind = itwg_pkg::KIND_LINEAR;
            default:                n0_kind = itwg_pkg::KIND_CUBIC;
        endcase
    end

    // Tap origin: rounded position for nearest, floor otherwise
    always_comb begin
        if (r0_kind == itwg_pkg::KIND_NEAREST) begin
            n1_x0 = round_int(r0_x);
            n1_y0 = round_int(r0_y);
        end else begin
            n1_x0 = floor_int(r0_x);
            n1_y0 = floor_int(r0_y);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_push;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Payload pipe
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_kind <= n0_kind;
            r0_x    <= i_x_coord;
            r0_y    <= i_y_coord;

            r1_kind <= r0_kind;
            r1_x0   <= n1_x0;
            r1_y0   <= n1_y0;
            r1_tx   <= r0_x[FRAC_BITS-1:0];
            r1_ty   <= r0_y[FRAC_BITS-1:0];
            r1_tx2  <= r0_x[FRAC_BITS-1:0] * r0_x[FRAC_BITS-1:0];
            r1_ty2  <= r0_y[FRAC_BITS-1:0] * r0_y[FRAC_BITS-1:0];

            r2_kind <= r1_kind;
            r2_x0   <= r1_x0;
            r2_y0   <= r1_y0;
            r2_tx   <= r1_tx;
            r2_ty   <= r1_ty;
            r2_tx2  <= r1_tx2;
            r2_ty2  <= r1_ty2;
            r2_tx3  <= r1_tx2 * r1_tx;
            r2_ty3  <= r1_ty2 * r1_ty;

            r3_kind <= r2_kind;
            r3_x0   <= r2_x0;
            r3_y0   <= r2_y0;
            r3_wx   <= axis_raw(r2_kind, r2_tx, r2_tx2, r2_tx3);
            r3_wy   <= axis_raw(r2_kind, r2_ty, r2_ty2, r2_ty3);
        end
    end

    // Job out to the queue
    always_comb begin
        o_job.valid = r3_valid;
        o_job.kind  = r3_kind;
        o_x0        = r3_x0;
        o_y0        = r3_y0;
        for (int k = 0; k < 4; k++) begin
            o_wx[k] = axis_fit(r3_kind, r3_wx[k]);
            o_wy[k] = axis_fit(r3_kind, r3_wy[k]);
        end
    end

endmodule

[rtl/itwg_back.sv]
`timescale 1ns / 1ps

module itwg_back #(
    parameter int FRAC_BITS        = 8,
    parameter int INT_BITS         = 16,
    parameter int WEIGHT_FRAC_BITS = 14,
    parameter int OUT_DEPTH        = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  itwg_pkg::t_job_ctl                     i_job,
    input  logic signed [INT_BITS:0]               i_x0,
    input  logic signed [INT_BITS:0]               i_y0,
    input  logic [3:0][((3*FRAC_BITS+1 > itwg_pkg::AXIS_MAX_FRAC) ?
                       itwg_pkg::AXIS_MAX_FRAC : 3*FRAC_BITS+1)+1:0] i_wx,
    input  logic [3:0][((3*FRAC_BITS+1 > itwg_pkg::AXIS_MAX_FRAC) ?
                       itwg_pkg::AXIS_MAX_FRAC : 3*FRAC_BITS+1)+1:0] i_wy,
    output logic                                   o_job_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]         i_out_count,
    output logic                                   o_out_wr,
    output logic signed [INT_BITS:0]               o_tap_x,
    output logic signed [INT_BITS:0]               o_tap_y,
    output logic signed [WEIGHT_FRAC_BITS+1:0]     o_tap_weight,
    output logic                                   o_last_tap
);

    localparam int TAP_W  = INT_BITS + 1;
    localparam int WGT_W  = WEIGHT_FRAC_BITS + 2;
    localparam int CUB_D  = 3 * FRAC_BITS + 1;
    localparam int AX_D   = (CUB_D > itwg_pkg::AXIS_MAX_FRAC) ?
                            itwg_pkg::AXIS_MAX_FRAC : CUB_D;
    localparam int AX_W   = AX_D + 2;
    localparam int PW     = 2 * AX_W;
    localparam int EW     = PW + WEIGHT_FRAC_BITS + 1;
    localparam int CW     = $clog2(OUT_DEPTH + 1);
    localparam int SH_LIN = 2 * FRAC_BITS - WEIGHT_FRAC_BITS;
    localparam int SH_CUB = 2 * AX_D - WEIGHT_FRAC_BITS;
    localparam int LIN_R  = (SH_LIN > 0) ? SH_LIN : 0;
    localparam int LIN_L  = (SH_LIN < 0) ? -SH_LIN : 0;
    localparam int CUB_R  = (SH_CUB > 0) ? SH_CUB : 0;
    localparam int CUB_L  = (SH_CUB < 0) ? -SH_CUB : 0;
    localparam logic [EW-1:0] LIN_HALF =
        EW'(LIN_R > 0) << ((LIN_R > 0) ? LIN_R - 1 : 0);
    localparam logic [EW-1:0] CUB_HALF =
        EW'(CUB_R > 0) << ((CUB_R > 0) ? CUB_R - 1 : 0);
    localparam logic [EW-1:0] NEG_LIM = EW'(1) << (WGT_W - 1);
    localparam logic [EW-1:0] POS_LIM = NEG_LIM - 1'b1;
    localparam logic signed [WGT_W-1:0] W_ONE = WGT_W'(1) << WEIGHT_FRAC_BITS;
    localparam logic signed [WGT_W-1:0] W_MAX = WGT_W'(POS_LIM);
    localparam logic signed [WGT_W-1:0] W_MIN = -W_MAX - 1'b1;

    // Tap sequencer
    logic [1:0]               r_col, n_col;
    logic [1:0]               r_row, n_row;
    logic                     w_room, w_issue;
    logic                     w_col_last, w_row_last, w_tap_last;
    logic [1:0]               w_off;
    logic signed [2:0]        w_dx, w_dy;
    logic signed [TAP_W-1:0]  w_tx, w_ty;
    logic signed [PW-1:0]     w_prod;

    // Product stage
    logic                     r_s1_valid;
    itwg_pkg::t_kind          r_s1_kind;
    logic signed [PW-1:0]     r_s1_p;
    logic signed [TAP_W-1:0]  r_s1_tx, r_s1_ty;
    logic                     r_s1_last;

    // Rounding
    logic signed [EW-1:0]     w_pe;
    logic [EW-1:0]            w_mag, w_lin, w_cub, w_sel;
    logic signed [WGT_W-1:0]  w_weight;

    // Issue one tap a cycle while the result queue has a free slot for it
    assign w_room  = ({1'b0, i_out_count} + (CW + 1)'(r_s1_valid)) < (CW + 1)'(OUT_DEPTH);
    assign w_issue = i_job.valid && w_room;

    always_comb begin
        case (i_job.kind)
            itwg_pkg::KIND_NEAREST: begin
                w_col_last = 1'b1;
                w_row_last = 1'b1;
                w_off      = 2'd0;
            end
            itwg_pkg::KIND_LINEAR: begin
                w_col_last = (r_col == 2'd1);
                w_row_last = (r_row == 2'd1);
                w_off      = 2'd0;
            end
            default: begin
                w_col_last = (r_col == 2'd3);
                w_row_last = (r_row == 2'd3);
                w_off      = 2'd1;
            end
        endcase
        w_tap_last = w_col_last && w_row_last;
        w_dx       = $signed({1'b0, r_col}) - $signed({1'b0, w_off});
        w_dy       = $signed({1'b0, r_row}) - $signed({1'b0, w_off});
        w_tx       = i_x0 + TAP_W'(w_dx);
        w_ty       = i_y0 + TAP_W'(w_dy);
        w_prod     = $signed(i_wx[r_col]) * $signed(i_wy[r_row]);

        n_col = r_col;
        n_row = r_row;
        if (w_issue) begin
            if (w_tap_last) begin
                n_col = 2'd0;
                n_row = 2'd0;
            end else if (w_col_last) begin
                n_col = 2'd0;
                n_row = r_row + 2'd1;
            end else begin
                n_col = r_col + 2'd1;
            end
        end
    end

    assign o_job_pop = w_issue && w_tap_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= 2'd0;
            r_row      <= 2'd0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_kind <= i_job.kind;
            r_s1_p    <= w_prod;
            r_s1_tx   <= w_tx;
            r_s1_ty   <= w_ty;
            r_s1_last <= w_tap_last;
        end
    end

    // Round the product to the weight format, half away from zero, then saturate; nearest is 1.0
    always_comb begin
        w_pe  = EW'(r_s1_p);
        w_mag = w_pe[EW-1] ? -w_pe : w_pe;
        w_lin = ((w_mag + LIN_HALF) >> LIN_R) << LIN_L;
        w_cub = ((w_mag + CUB_HALF) >> CUB_R) << CUB_L;
        w_sel = (r_s1_kind == itwg_pkg::KIND_LINEAR) ? w_lin : w_cub;
        if (r_s1_kind == itwg_pkg::KIND_NEAREST) begin
            w_weight = W_ONE;
        end else if (w_pe[EW-1]) begin
            w_weight = (w_sel > NEG_LIM) ? W_MIN : -WGT_W'(w_sel);
        end else begin
            w_weight = (w_sel > POS_LIM) ? W_MAX : WGT_W'(w_sel);
        end
    end

    assign o_out_wr     = r_s1_valid;
    assign o_tap_x      = r_s1_tx;
    assign o_tap_y      = r_s1_ty;
    assign o_tap_weight = w_weight;
    assign o_last_tap   = r_s1_last;

    // Sequencer starts every job at the top-left tap
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_col == 2'd0) && (r_row == 2'd0))
        else $error("tap counters not cleared after final tap");

    // Bilinear jobs stay inside the 2x2 window
    a_linear_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job.valid && i_job.kind == itwg_pkg::KIND_LINEAR) |->
            (r_col < 2'd2) && (r_row < 2'd2))
        else $error("bilinear tap counter out of range");

    // A nearest job never finds the counters mid-window
    a_nearest_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job.valid && i_job.kind == itwg_pkg::KIND_NEAREST) |->
            (r_col == 2'd0) && (r_row == 2'd0))
        else $error("nearest job issued with stale tap counters");

endmodule

[rtl/interp_tap_weight_generator.sv]
`timescale 1ns / 1ps

// Resampling tap and weight generator. Each transaction on the input queue is a
// sample position (x, y) in signed fixed point with FRAC_BITS fraction bits; the
// block returns the source taps around it with their weights, top row first and
// left to right, with last_tap on the final one: 16 taps with Catmull-Rom weights
// in bicubic mode, 4 in bilinear mode and one tap of weight 1.0 at the rounded
// position in nearest mode. Weights are signed with WEIGHT_FRAC_BITS fraction
// bits. Results leave at one tap per clock while the result queue has room for
// them; that rate is set by the back end, which forms one tap weight per cycle
// on a single multiplier and writes one result into the output queue per cycle.
// The front end (four stages, the axis weight polynomials) runs ahead through a
// two-entry job queue; a position passes the four front stages, the job queue,
// the back end's product register and the result queue before its first tap
// shows on the result ports. interp_mode sits at byte address 0; the user must
// write it only while the block is idle, and the block does not enforce this.

module interp_tap_weight_generator #(
    parameter int FRAC_BITS        = 8,
    parameter int INT_BITS         = 16,
    parameter int WEIGHT_FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // positions in
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [INT_BITS+FRAC_BITS-1:0]   i_x_coord,
    input  logic signed [INT_BITS+FRAC_BITS-1:0]   i_y_coord,
    // taps out
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [INT_BITS:0]               o_tap_x,
    output logic signed [INT_BITS:0]               o_tap_y,
    output logic signed [WEIGHT_FRAC_BITS+1:0]     o_tap_weight,
    output logic                                   o_last_tap
);

    localparam int TAP_W = INT_BITS + 1;
    localparam int WGT_W = WEIGHT_FRAC_BITS + 2;
    localparam int CUB_D = 3 * FRAC_BITS + 1;
    localparam int AX_D  = (CUB_D > itwg_pkg::AXIS_MAX_FRAC) ?
                           itwg_pkg::AXIS_MAX_FRAC : CUB_D;
    localparam int AX_W  = AX_D + 2;
    localparam int JW    = 2 + 2 * TAP_W + 8 * AX_W;
    localparam int RW    = 2 * TAP_W + WGT_W + 1;
    localparam int OCW   = $clog2(itwg_pkg::OUT_DEPTH + 1);
    localparam int JCW   = $clog2(itwg_pkg::JOB_DEPTH + 1);

    // Mode register
    logic [1:0] r_mode;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite &&
                      (paddr[2:2] == itwg_pkg::REG_INTERP_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= itwg_pkg::MODE_CUBIC;
        end else if (w_cfg_wr) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2:2] == itwg_pkg::REG_INTERP_MODE) ? {30'd0, r_mode} : 32'd0;

    // Front end
    itwg_pkg::t_job_ctl          w_front_job;
    logic signed [TAP_W-1:0]     w_front_x0, w_front_y0;
    logic [3:0][AX_W-1:0]        w_front_wx, w_front_wy;
    logic                        w_job_full, w_job_empty, w_job_wr, w_job_pop;
    logic [JW-1:0]               w_job_rdata;
    logic [JCW-1:0]              w_job_count;

    itwg_front #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_x_coord  (i_x_coord),
        .i_y_coord  (i_y_coord),
        .i_mode     (r_mode),
        .i_job_full (w_job_full),
        .o_job      (w_front_job),
        .o_x0       (w_front_x0),
        .o_y0       (w_front_y0),
        .o_wx       (w_front_wx),
        .o_wy       (w_front_wy)
    );

    // Job queue between front and back
    assign w_job_wr = w_front_job.valid && !w_job_full;

    itwg_queue #(
        .WIDTH (JW),
        .DEPTH (itwg_pkg::JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_job_wr),
        .i_wdata ({w_front_job.kind, w_front_x0, w_front_y0, w_front_wx, w_front_wy}),
        .i_rd    (w_job_pop),
        .o_rdata (w_job_rdata),
        .o_empty (w_job_empty),
        .o_full  (w_job_full),
        .o_count (w_job_count)
    );

    // Unpack the job at the queue head
    itwg_pkg::t_job_ctl          w_back_job;
    logic [1:0]                  w_back_kind_bits;
    logic signed [TAP_W-1:0]     w_back_x0, w_back_y0;
    logic [3:0][AX_W-1:0]        w_back_wx, w_back_wy;
    logic                        w_job_some;

    assign {w_back_kind_bits, w_back_x0, w_back_y0, w_back_wx, w_back_wy} = w_job_rdata;
    assign w_job_some       = (w_job_count != '0);
    assign w_back_job.valid = w_job_some && !w_job_empty;
    assign w_back_job.kind  = itwg_pkg::t_kind'(w_back_kind_bits);

    // Back end
    logic                        w_out_wr, w_out_rd, w_out_full;
    logic [OCW-1:0]              w_out_count;
    logic signed [TAP_W-1:0]     w_tap_x, w_tap_y;
    logic signed [WGT_W-1:0]     w_tap_weight;
    logic                        w_last_tap;
    logic [RW-1:0]               w_out_rdata;

    itwg_back #(
        .FRAC_BITS        (FRAC_BITS),
        .INT_BITS         (INT_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .OUT_DEPTH        (itwg_pkg::OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_back_job),
        .i_x0         (w_back_x0),
        .i_y0         (w_back_y0),
        .i_wx         (w_back_wx),
        .i_wy         (w_back_wy),
        .o_job_pop    (w_job_pop),
        .i_out_count  (w_out_count),
        .o_out_wr     (w_out_wr),
        .o_tap_x      (w_tap_x),
        .o_tap_y      (w_tap_y),
        .o_tap_weight (w_tap_weight),
        .o_last_tap   (w_last_tap)
    );

    // Result queue
    assign w_out_rd = pop && !empty;

    itwg_queue #(
        .WIDTH (RW),
        .DEPTH (itwg_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_out_wr),
        .i_wdata ({w_tap_x, w_tap_y, w_tap_weight, w_last_tap}),
        .i_rd    (w_out_rd),
        .o_rdata (w_out_rdata),
        .o_empty (empty),
        .o_full  (w_out_full),
        .o_count (w_out_count)
    );

    assign {o_tap_x, o_tap_y, o_tap_weight, o_last_tap} = w_out_rdata;

    // The back end reserves a slot before it issues, so the result queue never
    // fills with a tap still in flight
    a_out_reserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_full |-> !w_out_wr)
        else $error("result written into a full queue");

endmodule
